@@ sv/ycrc_pkg.sv @@
// ----------------------------------------------------------------------------
// ycrc_pkg
// Shared types, protocol codes and helpers of the YMODEM-CRC receiver.
// ----------------------------------------------------------------------------
package ycrc_pkg;

   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_STX = 8'h02;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_CAN = 8'h18;
   localparam logic [7:0] CH_C   = 8'h43;

   localparam logic [1:0] KIND_TX      = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_EVENT   = 2'd2;

   localparam logic [2:0] EV_ACCEPT  = 3'd0;
   localparam logic [2:0] EV_CRCBAD  = 3'd1;
   localparam logic [2:0] EV_HEADER  = 3'd2;
   localparam logic [2:0] EV_DONE    = 3'd3;
   localparam logic [2:0] EV_TIMEOUT = 3'd4;

   localparam logic [15:0] CRC_POLY      = 16'h1021;
   localparam logic [15:0] CRC_MSB       = 16'h8000;
   localparam logic [10:0] SHORT_SIZE    = 11'd128;
   localparam logic [10:0] LONG_SIZE     = 11'd1024;
   localparam logic [15:0] TIMEOUT_RESET = 16'd100;
   localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

   localparam int SLOT_COUNT = 6;
   localparam int SLOT_BITS  = $clog2(SLOT_COUNT);

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
      logic [2:0] code;
   } ycrc_slot_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0]                count;
      ycrc_slot_type [SLOT_COUNT-1:0]      slot;
      logic [31:0]                         offset;
   } ycrc_cmd_type;

   function automatic ycrc_slot_type mk_slot(input logic [1:0] kind,
                                             input logic [7:0] value,
                                             input logic [2:0] code);
      ycrc_slot_type s;
      s.kind  = kind;
      s.value = value;
      s.code  = code;
      return s;
   endfunction

endpackage

@@ sv/ycrc_channels.sv @@
// ----------------------------------------------------------------------------
// ycrc channels
// Valid/ready channel interfaces: receive items, results and register write.
// ----------------------------------------------------------------------------
interface ycrc_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] rx_byte;
   modport source (output valid, action, rx_byte, input ready);
   modport sink   (input valid, action, rx_byte, output ready);
endinterface

interface ycrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  byte_value;
   logic [2:0]  event_code;
   logic [31:0] file_offset;
   logic        last;
   modport source (output valid, kind, byte_value, event_code, file_offset, last,
                   input ready);
   modport sink   (input valid, kind, byte_value, event_code, file_offset, last,
                   output ready);
endinterface

interface ycrc_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ sv/ycrc_front.sv @@
// ----------------------------------------------------------------------------
// ycrc_front
// Protocol state machine: takes one byte or tick per transfer, updates the
// receiver state and emits a command listing the results it causes.
// ----------------------------------------------------------------------------
module ycrc_front (
   input  logic                  clock,
   input  logic                  reset,
   ycrc_req_if.sink              req_if,
   ycrc_csr_if.sink              csr_if,
   input  logic                  cmd_ready,
   output logic                  cmd_valid,
   output ycrc_pkg::ycrc_cmd_type cmd
);
   import ycrc_pkg::*;

   typedef enum logic [4:0] {
      PH_INIT = 5'b00001,
      PH_WAIT = 5'b00010,
      PH_BNUM = 5'b00100,
      PH_DATA = 5'b01000,
      PH_CRC  = 5'b10000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] timeout_ff;
   logic [7:0]  expected_ff, expected_in;
   logic        header_ff, header_in;
   logic [31:0] offset_ff, offset_in;
   logic [10:0] bib_ff, bib_in;
   logic        long_ff, long_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_hi_ff, crc_hi_in;
   logic [15:0] idle_ff, idle_in;

   logic                 accept;
   logic                 do_restart;
   logic [SLOT_BITS-1:0] n;
   logic [10:0]          size;
   ycrc_cmd_type         cmd_c;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc_i,
                                            input logic [7:0]  b);
      logic [15:0] c;
      c = crc_i ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_MSB) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   assign req_if.ready = cmd_ready;
   assign accept       = req_if.valid && cmd_ready;
   assign csr_if.ready = 1'b1;
   assign cmd_valid    = accept && (n != '0);
   assign cmd          = cmd_c;

   always_comb begin
      phase_in    = phase_ff;
      expected_in = expected_ff;
      header_in   = header_ff;
      offset_in   = offset_ff;
      bib_in      = bib_ff;
      long_in     = long_ff;
      crc_in      = crc_ff;
      crc_hi_in   = crc_hi_ff;
      idle_in     = idle_ff;
      do_restart  = 1'b0;
      n           = '0;
      cmd_c       = '0;
      size        = long_ff ? LONG_SIZE : SHORT_SIZE;

      if (phase_ff == PH_INIT) begin
         expected_in = 8'h00;
         offset_in   = 32'h0;
         header_in   = 1'b0;
         idle_in     = 16'h0;
         phase_in    = PH_WAIT;
         cmd_c.slot[n] = mk_slot(KIND_TX, CH_C, 3'd0);
         n = n + 1'b1;
      end

      if (req_if.action) begin
         if (phase_ff != PH_INIT) begin
            if (idle_in != IDLE_MAX) begin
               idle_in = idle_in + 16'd1;
            end
            if (idle_in >= timeout_ff) begin
               if (phase_in != PH_WAIT || offset_in != 32'h0) begin
                  cmd_c.slot[n] = mk_slot(KIND_EVENT, 8'h00, EV_TIMEOUT);
                  cmd_c.offset  = offset_in;
                  n = n + 1'b1;
               end
               do_restart = 1'b1;
            end
         end
      end else begin
         idle_in = 16'h0;
         case (phase_in)
            PH_BNUM: begin
               if (bib_in == 11'd0) begin
                  if (req_if.rx_byte == expected_in) begin
                     bib_in = 11'd1;
                  end else begin
                     do_restart = 1'b1;
                  end
               end else if (req_if.rx_byte == ~expected_in) begin
                  phase_in  = PH_DATA;
                  bib_in    = 11'd0;
                  crc_in    = 16'h0;
                  crc_hi_in = 8'h00;
               end else begin
                  cmd_c.slot[n] = mk_slot(KIND_EVENT, 8'h00, EV_TIMEOUT);
                  cmd_c.offset  = offset_in;
                  n = n + 1'b1;
                  do_restart = 1'b1;
               end
            end
            PH_DATA: begin
               cmd_c.slot[n] = mk_slot(KIND_PAYLOAD, req_if.rx_byte, 3'd0);
               cmd_c.offset  = offset_in + {21'h0, bib_in};
               n = n + 1'b1;
               crc_in = crc_byte(crc_in, req_if.rx_byte);
               bib_in = bib_in + 11'd1;
               if (bib_in >= size) begin
                  bib_in   = 11'd0;
                  phase_in = PH_CRC;
               end
            end
            PH_CRC: begin
               if (bib_in == 11'd0) begin
                  crc_hi_in = req_if.rx_byte;
                  bib_in    = 11'd1;
               end else begin
                  phase_in = PH_WAIT;
                  if (crc_in == {crc_hi_in, req_if.rx_byte}) begin
                     cmd_c.slot[n] = mk_slot(KIND_TX, CH_ACK, 3'd0);
                     n = n + 1'b1;
                     cmd_c.offset = offset_in;
                     if (!header_in && expected_in == 8'h00) begin
                        cmd_c.slot[n] = mk_slot(KIND_EVENT, 8'h00, EV_HEADER);
                        n = n + 1'b1;
                        header_in = 1'b1;
                        cmd_c.slot[n] = mk_slot(KIND_TX, CH_C, 3'd0);
                        n = n + 1'b1;
                     end else begin
                        cmd_c.slot[n] = mk_slot(KIND_EVENT, 8'h00, EV_ACCEPT);
                        n = n + 1'b1;
                        offset_in = offset_in + {21'h0, size};
                     end
                     expected_in = expected_in + 8'd1;
                  end else begin
                     cmd_c.slot[n] = mk_slot(KIND_TX, CH_NAK, 3'd0);
                     n = n + 1'b1;
                     cmd_c.slot[n] = mk_slot(KIND_EVENT, 8'h00, EV_CRCBAD);
                     n = n + 1'b1;
                     cmd_c.offset = offset_in;
                  end
               end
            end
            default: begin
               if (req_if.rx_byte == CH_SOH || req_if.rx_byte == CH_STX) begin
                  bib_in   = 11'd0;
                  long_in  = (req_if.rx_byte == CH_STX);
                  phase_in = PH_BNUM;
               end else if (req_if.rx_byte == CH_EOT) begin
                  cmd_c.slot[n] = mk_slot(KIND_TX, CH_ACK, 3'd0);
                  n = n + 1'b1;
                  cmd_c.slot[n] = mk_slot(KIND_TX, CH_C, 3'd0);
                  n = n + 1'b1;
                  cmd_c.slot[n] = mk_slot(KIND_TX, CH_ACK, 3'd0);
                  n = n + 1'b1;
                  cmd_c.slot[n] = mk_slot(KIND_EVENT, 8'h00, EV_DONE);
                  n = n + 1'b1;
                  cmd_c.offset = offset_in;
                  do_restart = 1'b1;
               end
            end
         endcase
      end

      if (do_restart) begin
         expected_in = 8'h00;
         offset_in   = 32'h0;
         header_in   = 1'b0;
         idle_in     = 16'h0;
         phase_in    = PH_WAIT;
         cmd_c.slot[n] = mk_slot(KIND_TX, CH_C, 3'd0);
         n = n + 1'b1;
      end
      cmd_c.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_INIT;
         timeout_ff  <= TIMEOUT_RESET;
         expected_ff <= 8'h00;
         header_ff   <= 1'b0;
         offset_ff   <= 32'h0;
         bib_ff      <= 11'd0;
         long_ff     <= 1'b0;
         crc_ff      <= 16'h0;
         crc_hi_ff   <= 8'h00;
         idle_ff     <= 16'h0;
      end else begin
         if (csr_if.valid) begin
            timeout_ff <= csr_if.data;
         end
         if (accept) begin
            phase_ff    <= phase_in;
            expected_ff <= expected_in;
            header_ff   <= header_in;
            offset_ff   <= offset_in;
            bib_ff      <= bib_in;
            long_ff     <= long_in;
            crc_ff      <= crc_in;
            crc_hi_ff   <= crc_hi_in;
            idle_ff     <= idle_in;
         end
      end
   end

endmodule

@@ sv/ycrc_queue.sv @@
// ----------------------------------------------------------------------------
// ycrc_queue
// Two-entry command queue between the state machine and the result sequencer.
// ----------------------------------------------------------------------------
module ycrc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  ycrc_pkg::ycrc_cmd_type push_cmd,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output ycrc_pkg::ycrc_cmd_type pop_cmd
);
   import ycrc_pkg::*;

   ycrc_cmd_type entry_ff [2];
   logic         wr_ptr_ff;
   logic         rd_ptr_ff;
   logic [1:0]   count_ff, count_in;
   logic         do_push;
   logic         do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

endmodule

@@ sv/ycrc_back.sv @@
// ----------------------------------------------------------------------------
// ycrc_back
// Result sequencer: plays out the slots of one command, one transfer a cycle while rsp_if is ready.
// ----------------------------------------------------------------------------
module ycrc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   input  ycrc_pkg::ycrc_cmd_type cmd,
   ycrc_rsp_if.source             rsp_if
);
   import ycrc_pkg::*;

   ycrc_cmd_type         cur_ff;
   logic [SLOT_BITS-1:0] idx_ff;
   logic                 busy_ff;
   ycrc_slot_type        slot;
   logic                 is_last;

   assign slot    = cur_ff.slot[idx_ff];
   assign is_last = (idx_ff == cur_ff.count - 1'b1);

   assign cmd_ready = !busy_ff || (rsp_if.ready && is_last);

   assign rsp_if.valid       = busy_ff;
   assign rsp_if.kind        = slot.kind;
   assign rsp_if.byte_value  = slot.value;
   assign rsp_if.event_code  = slot.code;
   assign rsp_if.file_offset = (slot.kind == KIND_TX) ? 32'h0 : cur_ff.offset;
   assign rsp_if.last        = is_last;

   always_ff @(posedge clock) begin
      if (cmd_valid && cmd_ready) begin
         cur_ff <= cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (cmd_ready) begin
         busy_ff <= cmd_valid;
         idx_ff  <= '0;
      end else if (rsp_if.ready) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

endmodule

@@ sv/ymodem_crc_receiver.sv @@
// ----------------------------------------------------------------------------
// ymodem_crc_receiver
// YMODEM-CRC receiver: framing, block number check, CRC-16 and idle timeout.
// ----------------------------------------------------------------------------
// Usage:
//   req_if  : one received byte (action 0) or one timer tick (action 1) per
//             transfer.
//   rsp_if  : results - bytes to transmit, payload bytes with file offset,
//             and events; last marks the final result of one input.
//   csr_if  : write of timeout_ticks, always ready; write only while idle.
// Path: an input's command is registered in the command queue and then in
//   the result sequencer before its first result is offered on rsp_if.
//   An input causes zero to six results, one per cycle while rsp_if is ready.
// Throughput: one input per cycle; req_if.ready drops only when the
//   two-entry command queue is full, set by the result sequencer playing
//   out multi-result inputs.
// Reset: timeout_ticks returns to 100; the first input after reset also
//   emits the opening 'C'.
// A stalled rsp_if holds its result; the front keeps accepting until the
//   queue fills.
// ----------------------------------------------------------------------------
module ymodem_crc_receiver (
   input  logic       clock,
   input  logic       reset,
   ycrc_req_if.sink   req_if,
   ycrc_csr_if.sink   csr_if,
   ycrc_rsp_if.source rsp_if
);
   import ycrc_pkg::*;

   logic         f_valid, f_ready;
   ycrc_cmd_type f_cmd;
   logic         b_valid, b_ready;
   ycrc_cmd_type b_cmd;

   ycrc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .csr_if    (csr_if),
      .cmd_ready (f_ready),
      .cmd_valid (f_valid),
      .cmd       (f_cmd)
   );

   ycrc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_cmd   (f_cmd),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_cmd    (b_cmd)
   );

   ycrc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (b_valid),
      .cmd_ready (b_ready),
      .cmd       (b_cmd),
      .rsp_if    (rsp_if)
   );

endmodule
